@@ src/bbo_pkg.sv @@
package bbo_pkg;

    localparam int DATA_W = 80;
    localparam int COORD_IN_W = 14;
    localparam int CFG_W = 13;
    localparam int SIZE_W = 14;
    localparam int RGB_W = 24;
    localparam logic [7:0] COLOR_FULL = 8'd255;
    localparam logic [7:0] COLOR_NONE = 8'd0;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_PIXEL = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_STORED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic    valid;
        t_kind   kind;
        logic    hit;
        t_status status;
    } t_ctl;

endpackage

@@ src/bbo_head.sv @@
module bbo_head #(
    parameter int MAX_BOXES = 16,
    parameter int MAX_DIMENSION = 4096,
    parameter int CW = 12,
    parameter int NW = 5,
    parameter int IW = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_take,
    input  logic [1:0]                      i_action,
    input  logic [bbo_pkg::COORD_IN_W-1:0]  i_box_left,
    input  logic [bbo_pkg::COORD_IN_W-1:0]  i_box_top,
    input  logic [bbo_pkg::COORD_IN_W-1:0]  i_box_right,
    input  logic [bbo_pkg::COORD_IN_W-1:0]  i_box_bottom,
    input  logic [bbo_pkg::CFG_W-1:0]       i_frame_width,
    input  logic [bbo_pkg::CFG_W-1:0]       i_frame_height,
    output bbo_pkg::t_ctl                   o_ctl,
    output logic [CW-1:0]                   o_col,
    output logic [CW-1:0]                   o_row,
    output logic [NW-1:0]                   o_count,
    output logic [IW-1:0]                   o_load_idx,
    output logic [4*CW-1:0]                 o_box
);
    import bbo_pkg::*;

    localparam logic [SIZE_W-1:0] MAXD = SIZE_W'(MAX_DIMENSION);
    localparam int SW = COORD_IN_W + 1;

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [NW-1:0] r_count, n_count;
    logic [SIZE_W-1:0] w_width, w_height;
    logic signed [SW-1:0] w_left, w_top, w_right, w_bottom, w_wmax, w_hmax;
    logic w_empty;
    t_kind w_kind;
    t_status w_status;

    always_comb begin
        if (i_frame_width == '0) begin
            w_width = SIZE_W'(1);
        end else if ({1'b0, i_frame_width} > MAXD) begin
            w_width = MAXD;
        end else begin
            w_width = {1'b0, i_frame_width};
        end
        if (i_frame_height == '0) begin
            w_height = SIZE_W'(1);
        end else if ({1'b0, i_frame_height} > MAXD) begin
            w_height = MAXD;
        end else begin
            w_height = {1'b0, i_frame_height};
        end
    end

    always_comb begin
        w_wmax   = $signed({1'b0, w_width - SIZE_W'(1)});
        w_hmax   = $signed({1'b0, w_height - SIZE_W'(1)});
        w_left   = $signed({i_box_left[COORD_IN_W-1], i_box_left});
        w_top    = $signed({i_box_top[COORD_IN_W-1], i_box_top});
        w_right  = $signed({i_box_right[COORD_IN_W-1], i_box_right});
        w_bottom = $signed({i_box_bottom[COORD_IN_W-1], i_box_bottom});
        if (w_left < 0) begin
            w_left = '0;
        end
        if (w_top < 0) begin
            w_top = '0;
        end
        if (w_right > w_wmax) begin
            w_right = w_wmax;
        end
        if (w_bottom > w_hmax) begin
            w_bottom = w_hmax;
        end
        w_empty = (w_left >= w_right) || (w_top >= w_bottom);
    end

    always_comb begin
        w_kind   = t_kind'(i_action);
        n_col    = r_col;
        n_row    = r_row;
        n_count  = r_count;
        w_status = ST_DONE;
        unique case (w_kind)
            KIND_FRAME: begin
                n_col   = '0;
                n_row   = '0;
                n_count = '0;
            end
            KIND_LOAD: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (r_count >= NW'(MAX_BOXES)) begin
                    w_status = ST_FULL;
                end else begin
                    w_status = ST_STORED;
                    n_count  = r_count + NW'(1);
                end
            end
            KIND_PIXEL: begin
                if (SIZE_W'(r_col) + SIZE_W'(1) >= w_width) begin
                    n_col = '0;
                    if (SIZE_W'(r_row) + SIZE_W'(1) >= w_height) begin
                        n_row = '0;
                    end else begin
                        n_row = r_row + CW'(1);
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            KIND_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_count <= '0;
        end else if (i_take) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_count <= n_count;
        end
    end

    assign o_ctl.valid  = i_valid;
    assign o_ctl.kind   = w_kind;
    assign o_ctl.hit    = 1'b0;
    assign o_ctl.status = w_status;
    assign o_col        = r_col;
    assign o_row        = r_row;
    assign o_count      = r_count;
    assign o_load_idx   = r_count[IW-1:0];
    assign o_box        = {w_bottom[CW-1:0], w_right[CW-1:0], w_top[CW-1:0], w_left[CW-1:0]};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(MAX_BOXES))
        else $error("box count above table size");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && w_kind == KIND_FRAME |=> r_count == '0 && r_col == '0 && r_row == '0)
        else $error("frame start did not clear position and count");

    a_store_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && w_status == ST_STORED |=> r_count == $past(r_count) + NW'(1))
        else $error("stored box did not advance count");

endmodule

@@ src/bbo_cell.sv @@
module bbo_cell #(
    parameter int CW = 12,
    parameter int NW = 5,
    parameter int IW = 4,
    parameter int INDEX = 0,
    parameter int THICKNESS = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  bbo_pkg::t_ctl           i_ctl,
    input  logic [CW-1:0]           i_col,
    input  logic [CW-1:0]           i_row,
    input  logic [NW-1:0]           i_count,
    input  logic [IW-1:0]           i_load_idx,
    input  logic [4*CW-1:0]         i_box,
    input  logic [bbo_pkg::RGB_W-1:0] i_rgb,
    output bbo_pkg::t_ctl           o_ctl,
    output logic [CW-1:0]           o_col,
    output logic [CW-1:0]           o_row,
    output logic [NW-1:0]           o_count,
    output logic [IW-1:0]           o_load_idx,
    output logic [4*CW-1:0]         o_box,
    output logic [bbo_pkg::RGB_W-1:0] o_rgb
);
    import bbo_pkg::*;

    localparam int EW = CW + 4;

    t_ctl r_ctl, n_ctl;
    logic [CW-1:0] r_col, r_row;
    logic [NW-1:0] r_count;
    logic [IW-1:0] r_load_idx;
    logic [4*CW-1:0] r_box;
    logic [RGB_W-1:0] r_rgb;
    logic [CW-1:0] r_left, r_top, r_right, r_bottom;
    logic [EW-1:0] w_c, w_r, w_l, w_t, w_rt, w_b;
    logic w_owned, w_in_cols, w_in_rows, w_row_edge, w_col_edge, w_match, w_store;

    always_comb begin
        w_c  = EW'(i_col);
        w_r  = EW'(i_row);
        w_l  = EW'(r_left);
        w_t  = EW'(r_top);
        w_rt = EW'(r_right);
        w_b  = EW'(r_bottom);
        w_owned    = NW'(INDEX) < i_count;
        w_in_cols  = (w_c >= w_l) && (w_c <= w_rt);
        w_in_rows  = (w_r >= w_t) && (w_r <= w_b);
        w_row_edge = ((w_r >= w_t) && (w_r < w_t + EW'(THICKNESS)))
                  || ((w_r <= w_b) && (w_r + EW'(THICKNESS) > w_b));
        w_col_edge = ((w_c >= w_l) && (w_c < w_l + EW'(THICKNESS)))
                  || ((w_c <= w_rt) && (w_c + EW'(THICKNESS) > w_rt));
        w_match = w_owned && ((w_in_cols && w_row_edge) || (w_in_rows && w_col_edge));
        n_ctl = i_ctl;
        n_ctl.hit = i_ctl.hit || (i_ctl.kind == KIND_PIXEL && w_match);
        w_store = i_adv && i_ctl.valid && i_ctl.kind == KIND_LOAD
               && i_ctl.status == ST_STORED && i_load_idx == IW'(INDEX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_col      <= i_col;
            r_row      <= i_row;
            r_count    <= i_count;
            r_load_idx <= i_load_idx;
            r_box      <= i_box;
            r_rgb      <= i_rgb;
        end
        if (w_store) begin
            r_left   <= i_box[CW-1:0];
            r_top    <= i_box[2*CW-1:CW];
            r_right  <= i_box[3*CW-1:2*CW];
            r_bottom <= i_box[4*CW-1:3*CW];
        end
    end

    assign o_ctl      = r_ctl;
    assign o_col      = r_col;
    assign o_row      = r_row;
    assign o_count    = r_count;
    assign o_load_idx = r_load_idx;
    assign o_box      = r_box;
    assign o_rgb      = r_rgb;

endmodule

@@ src/bbox_border_overlay.sv @@
// An accepted item passes through the row of MAX_BOXES box cells, each a register stage, on the way to its result.
// Throughput: one item per cycle; the whole cell row advances together and holds while the
// result at its end is not taken.
// Reset clears the raster position, the box count and all item valid flags, and loads the
// frame size registers with 1920 by 1080. The box cells need no clearing after reset.
module bbox_border_overlay #(
    parameter int MAX_BOXES = 16,
    parameter int BORDER_THICKNESS = 2,
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // box_left, box_top, box_right, box_bottom, pixel_red, pixel_green, pixel_blue
    input  logic [bbo_pkg::DATA_W-1:0]   i_s_axis_tdata,
    // action
    input  logic [1:0]                   i_s_axis_tuser,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // out_red, out_green, out_blue
    output logic [bbo_pkg::RGB_W-1:0]    o_m_axis_tdata,
    // on_border, status
    output logic [2:0]                   o_m_axis_tuser,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [bbo_pkg::CFG_W-1:0]    i_cfg_data
);
    import bbo_pkg::*;

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int NW = $clog2(MAX_BOXES + 1);
    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int N = MAX_BOXES;

    logic [CFG_W-1:0] r_frame_width, r_frame_height;
    logic w_adv, w_take, w_pixel, w_hit;
    t_ctl w_ctl [N+1];
    logic [CW-1:0] w_col [N+1];
    logic [CW-1:0] w_row [N+1];
    logic [NW-1:0] w_count [N+1];
    logic [IW-1:0] w_idx [N+1];
    logic [4*CW-1:0] w_box [N+1];
    logic [RGB_W-1:0] w_rgb [N+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(1920);
            r_frame_height <= CFG_W'(1080);
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_adv = !w_ctl[N].valid || i_m_axis_tready;
    assign w_take = i_s_axis_tvalid && w_adv;
    assign o_s_axis_tready = w_adv;
    assign w_rgb[0] = i_s_axis_tdata[79:56];

    bbo_head #(
        .MAX_BOXES(MAX_BOXES),
        .MAX_DIMENSION(MAX_DIMENSION),
        .CW(CW),
        .NW(NW),
        .IW(IW)
    ) u_head (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_axis_tvalid),
        .i_take(w_take),
        .i_action(i_s_axis_tuser),
        .i_box_left(i_s_axis_tdata[13:0]),
        .i_box_top(i_s_axis_tdata[27:14]),
        .i_box_right(i_s_axis_tdata[41:28]),
        .i_box_bottom(i_s_axis_tdata[55:42]),
        .i_frame_width(r_frame_width),
        .i_frame_height(r_frame_height),
        .o_ctl(w_ctl[0]),
        .o_col(w_col[0]),
        .o_row(w_row[0]),
        .o_count(w_count[0]),
        .o_load_idx(w_idx[0]),
        .o_box(w_box[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        bbo_cell #(
            .CW(CW),
            .NW(NW),
            .IW(IW),
            .INDEX(g),
            .THICKNESS(BORDER_THICKNESS)
        ) u_cell (
            .i_clk(i_clk),
            .i_rst_n(i_rst_n),
            .i_adv(w_adv),
            .i_ctl(w_ctl[g]),
            .i_col(w_col[g]),
            .i_row(w_row[g]),
            .i_count(w_count[g]),
            .i_load_idx(w_idx[g]),
            .i_box(w_box[g]),
            .i_rgb(w_rgb[g]),
            .o_ctl(w_ctl[g+1]),
            .o_col(w_col[g+1]),
            .o_row(w_row[g+1]),
            .o_count(w_count[g+1]),
            .o_load_idx(w_idx[g+1]),
            .o_box(w_box[g+1]),
            .o_rgb(w_rgb[g+1])
        );
    end

    assign w_pixel = w_ctl[N].kind == KIND_PIXEL;
    assign w_hit = w_pixel && w_ctl[N].hit;

    always_comb begin
        if (w_hit) begin
            o_m_axis_tdata = {COLOR_NONE, COLOR_NONE, COLOR_FULL};
        end else if (w_pixel) begin
            o_m_axis_tdata = w_rgb[N];
        end else begin
            o_m_axis_tdata = '0;
        end
    end

    assign o_m_axis_tvalid = w_ctl[N].valid;
    assign o_m_axis_tuser = {w_ctl[N].status, w_hit};

    a_border_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tuser[2:1] == ST_DONE)
        else $error("border pixel with a load status");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("item taken while result row is stalled");

endmodule

@@ test/tb_top.sv @@
module tb_top;
    import bbo_pkg::*;

    localparam int BOX_SLOTS = 16;
    localparam int EDGE_WIDTH = 2;
    localparam int DIM_LIMIT = 4096;
    localparam int ITEM_TARGET = 1375;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES = 24;
    localparam int PRESSURE_PHASE = 4;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       border;
        t_status    status;
    } t_paint;

    typedef struct {
        int left;
        int top;
        int right;
        int bottom;
    } t_rect;

    class overlay_checker;
        int     width_reg;
        int     height_reg;
        t_rect  boxes[BOX_SLOTS];
        int     box_count;
        int     col;
        int     row;
        int     failures;
        t_paint painted_queue[$];

        function new();
            width_reg = 1920;
            height_reg = 1080;
            box_count = 0;
            col = 0;
            row = 0;
            failures = 0;
        endfunction

        static function int eff_dim(int v);
            if (v < 1) begin
                return 1;
            end
            if (v > DIM_LIMIT) begin
                return DIM_LIMIT;
            end
            return v;
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] value);
            if (t_reg'(idx) == REG_FRAME_WIDTH) begin
                width_reg = int'(value);
            end else begin
                height_reg = int'(value);
            end
        endfunction

        function bit hits_border(int c, int r);
            bit in_cols;
            bit in_rows;
            for (int i = 0; i < box_count; i++) begin
                in_cols = c >= boxes[i].left && c <= boxes[i].right;
                in_rows = r >= boxes[i].top && r <= boxes[i].bottom;
                if (in_cols && ((r >= boxes[i].top && r < boxes[i].top + EDGE_WIDTH) ||
                        (r <= boxes[i].bottom && r > boxes[i].bottom - EDGE_WIDTH))) begin
                    return 1'b1;
                end
                if (in_rows && ((c >= boxes[i].left && c < boxes[i].left + EDGE_WIDTH) ||
                        (c <= boxes[i].right && c > boxes[i].right - EDGE_WIDTH))) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_item(logic [1:0] kind, logic [DATA_W-1:0] data);
            t_paint res;
            int w;
            int h;
            int l;
            int t;
            int r;
            int b;
            res.red = COLOR_NONE;
            res.green = COLOR_NONE;
            res.blue = COLOR_NONE;
            res.border = 1'b0;
            res.status = ST_DONE;
            w = eff_dim(width_reg);
            h = eff_dim(height_reg);
            case (t_kind'(kind))
                KIND_FRAME: begin
                    box_count = 0;
                    col = 0;
                    row = 0;
                end
                KIND_LOAD: begin
                    l = $signed(data[13:0]);
                    t = $signed(data[27:14]);
                    r = $signed(data[41:28]);
                    b = $signed(data[55:42]);
                    if (l < 0) l = 0;
                    if (t < 0) t = 0;
                    if (r > w - 1) r = w - 1;
                    if (b > h - 1) b = h - 1;
                    if (l >= r || t >= b) begin
                        res.status = ST_EMPTY;
                    end else if (box_count >= BOX_SLOTS) begin
                        res.status = ST_FULL;
                    end else begin
                        boxes[box_count] = '{l, t, r, b};
                        box_count++;
                        res.status = ST_STORED;
                    end
                end
                KIND_PIXEL: begin
                    if (hits_border(col, row)) begin
                        res.red = COLOR_FULL;
                        res.border = 1'b1;
                    end else begin
                        res.red = data[63:56];
                        res.green = data[71:64];
                        res.blue = data[79:72];
                    end
                    if (col + 1 >= w) begin
                        col = 0;
                        row = (row + 1 >= h) ? 0 : row + 1;
                    end else begin
                        col++;
                    end
                end
                default: begin
                end
            endcase
            painted_queue.push_back(res);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_output(logic [RGB_W-1:0] data, logic [2:0] user);
            t_paint want;
            if (painted_queue.size() == 0) begin
                $error("output item arrived with no prediction pending");
                failures++;
                return;
            end
            want = painted_queue.pop_front();
            compare_field("out_red", want.red, data[7:0]);
            compare_field("out_green", want.green, data[15:8]);
            compare_field("out_blue", want.blue, data[23:16]);
            compare_field("on_border", want.border, user[0]);
            compare_field("status", want.status, user[2:1]);
        endfunction

        function int pending();
            return painted_queue.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_valid;
    logic              s_ready;
    logic [DATA_W-1:0] s_data;
    logic [1:0]        s_user;
    logic              m_valid;
    logic              m_ready;
    logic [RGB_W-1:0]  m_data;
    logic [2:0]        m_user;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    overlay_checker chk;
    int  burst_left;
    int  items_sent;
    bit  quiet;
    bit  hold_req;

    bbox_border_overlay #(
        .MAX_BOXES(BOX_SLOTS),
        .BORDER_THICKNESS(EDGE_WIDTH),
        .MAX_DIMENSION(DIM_LIMIT)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data),
        .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data),
        .o_m_axis_tuser(m_user),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #(20 * 400000);
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if (cfg_valid && cfg_ready) begin
                chk.set_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                chk.note_item(s_user, s_data);
            end
            if (m_valid && m_ready) begin
                chk.check_output(m_data, m_user);
            end
        end
    end

    initial begin
        int seg_left;
        int mode;
        seg_left = 0;
        mode = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 120);
                end
                seg_left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (seg_left % 3 != 0);
                endcase
            end
        end
    end

    function automatic logic [DATA_W-1:0] rand_word();
        return DATA_W'({$urandom, $urandom, $urandom});
    endfunction

    function automatic logic [DATA_W-1:0] box_word(int l, int t, int r, int b);
        logic [DATA_W-1:0] word;
        word = rand_word();
        word[55:0] = {b[13:0], r[13:0], t[13:0], l[13:0]};
        return word;
    endfunction

    task automatic send_item(input t_kind kind, input logic [DATA_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = quiet ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_user <= kind;
        s_data <= data;
        do @(posedge clk); while (!s_ready);
        items_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge clk);
        while (chk.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_random_box(input int w, input int h);
        int sel;
        int l;
        int t;
        int r;
        int b;
        int span_w;
        int span_h;
        span_w = (w < 48) ? w : 48;
        span_h = (h < 16) ? h : 16;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            l = $urandom_range(0, span_w - 1) - $urandom_range(0, 1) * $urandom_range(0, 3);
            r = l + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 8191 - 48) :
                $urandom_range(1, 14));
            t = $urandom_range(0, span_h - 1) - $urandom_range(0, 1) * $urandom_range(0, 3);
            b = t + $urandom_range(1, 8);
        end else if (sel == 7) begin
            l = $urandom_range(0, 16383);
            t = $urandom_range(0, 16383);
            r = $urandom_range(0, 16383);
            b = $urandom_range(0, 16383);
        end else if (sel == 8) begin
            l = $urandom_range(0, span_w - 1);
            t = $urandom_range(0, span_h - 1);
            r = ($urandom_range(0, 1) == 0) ? l : l - $urandom_range(1, 5);
            b = t + $urandom_range(0, 4);
        end else begin
            l = -$urandom_range(0, 100);
            t = -$urandom_range(0, 100);
            r = 8191 - $urandom_range(0, 1);
            b = 8191 - $urandom_range(0, 1);
        end
        send_item(KIND_LOAD, box_word(l, t, r, b));
    endtask

    initial begin
        int phase_w[9];
        int phase_h[9];
        int phase;
        int w;
        int h;
        int area;
        int npix;
        int nbox;
        int nframes;
        int sel;

        phase_w = '{16, 1, 0, 8191, 4096, 5, 2, 24, 7};
        phase_h = '{12, 1, 0, 8191, 4096, 3, 2, 10, 4095};
        chk = new();
        burst_left = 0;
        items_sent = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        rst_n <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        s_user <= KIND_FRAME;
        cfg_valid <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset frame size of 1920 by 1080.
        send_item(KIND_FRAME, rand_word());
        send_item(KIND_LOAD, box_word(-8192, -8192, 8191, 8191));
        send_item(KIND_LOAD, box_word(100, 5, 100, 50));
        send_item(KIND_LOAD, box_word(10, 60, 50, 20));
        for (int i = 0; i < 15; i++) begin
            send_item(KIND_LOAD, box_word(3 + i * 7, i, 8 + i * 7, i + 3));
        end
        send_item(KIND_LOAD, box_word(0, 0, 30, 30));
        send_item(KIND_LOAD, box_word(40, 2, 40, 9));
        send_item(KIND_PIXEL, {8'd255, 8'd255, 8'd255, 56'd0});
        send_item(KIND_PIXEL, {24'd0, {56{1'b1}}});
        send_item(KIND_PIXEL, rand_word());
        send_item(KIND_NONE, {DATA_W{1'b1}});

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            if (phase < 9) begin
                w = phase_w[phase];
                h = phase_h[phase];
            end else if ($urandom_range(0, 9) == 0) begin
                w = $urandom_range(1, 8191);
                h = $urandom_range(1, 8191);
            end else begin
                w = $urandom_range(1, 40);
                h = $urandom_range(1, 30);
            end
            sel = (phase < 9) ? 0 : $urandom_range(0, 7);
            if (sel != 1) begin
                write_reg(REG_FRAME_WIDTH, w);
            end else begin
                w = chk.width_reg;
            end
            if (sel != 2) begin
                write_reg(REG_FRAME_HEIGHT, h);
            end else begin
                h = chk.height_reg;
            end
            w = overlay_checker::eff_dim(w);
            h = overlay_checker::eff_dim(h);
            area = w * h;
            nframes = $urandom_range(1, 2);
            for (int f = 0; f < nframes; f++) begin
                // Skipping the frame start keeps the old boxes and raster position.
                if (f > 0 || $urandom_range(0, 9) < 8) begin
                    send_item(KIND_FRAME, rand_word());
                end
                nbox = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 20) :
                    $urandom_range(0, 8);
                for (int k = 0; k < nbox; k++) begin
                    load_random_box(w, h);
                end
                npix = (area <= 150) ? area + $urandom_range(0, 8) : $urandom_range(60, 150);
                if (phase == PRESSURE_PHASE && f == 0) begin
                    quiet = 1'b1;
                    hold_req = 1'b1;
                end
                for (int k = 0; k < npix; k++) begin
                    sel = $urandom_range(0, 49);
                    if (sel == 0) begin
                        send_item(KIND_NONE, rand_word());
                    end else if (sel == 1) begin
                        load_random_box(w, h);
                    end else begin
                        send_item(KIND_PIXEL, rand_word());
                    end
                end
                quiet = 1'b0;
            end
            phase++;
        end
        settle();

        if (chk.failures == 0 && chk.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
src/bbo_pkg.sv
src/bbo_head.sv
src/bbo_cell.sv
src/bbox_border_overlay.sv
test/tb_top.sv
